>>> hdl/fedl_pkg.sv
// Shared types, constants and arithmetic helpers of the feedback echo delay line.
`default_nettype none

package fedl_pkg;

	localparam int unsigned MAX_DELAY = 8192;
	localparam int unsigned ADDR_W    = $clog2(MAX_DELAY);
	localparam int unsigned LEN_W     = $clog2(MAX_DELAY + 1);

	localparam int unsigned SAMPLE_W = 16;
	localparam int unsigned GAIN_W   = 16;
	localparam int unsigned MS_W     = 11;
	localparam int unsigned RATE_W   = 17;
	localparam int unsigned KHZ_SHIFT = 10;
	localparam int unsigned KHZ_W    = RATE_W + 1 - KHZ_SHIFT;
	localparam int unsigned PLEN_W   = MS_W + KHZ_W;

	localparam int unsigned CFG_DATA_W = 17;
	localparam int unsigned CFG_IDX_W  = 2;

	localparam logic [CFG_IDX_W-1:0] REG_FEEDBACK_GAIN  = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_ECHO_DELAY_MS  = 2'd1;
	localparam logic [CFG_IDX_W-1:0] REG_SAMPLE_RATE_HZ = 2'd2;

	localparam logic [RATE_W:0]   RATE_ROUND  = 18'd512;
	localparam logic [RATE_W-1:0] RATE_RESET  = 17'd48000;
	localparam logic [LEN_W-1:0]  LEN_MAX     = LEN_W'(MAX_DELAY);
	localparam logic [LEN_W-1:0]  LEN_MIN     = LEN_W'(1);

	typedef logic signed [SAMPLE_W-1:0] sample_t;
	typedef logic signed [GAIN_W-1:0]   gain_t;
	typedef logic [ADDR_W-1:0]          addr_t;
	typedef logic [LEN_W-1:0]           len_t;

	// Saturates a 17-bit signed value to the 16-bit sample range.
	function automatic sample_t sat16(input logic signed [SAMPLE_W:0] x);
		sample_t r;
		if (x[SAMPLE_W] != x[SAMPLE_W-1]) begin
			r = x[SAMPLE_W] ? {1'b1, {(SAMPLE_W-1){1'b0}}} : {1'b0, {(SAMPLE_W-1){1'b1}}};
		end else begin
			r = x[SAMPLE_W-1:0];
		end
		return r;
	endfunction

	// Delay length from milliseconds and the rate rounded to units of 1024 Hz, clamped to 1..MAX_DELAY.
	function automatic len_t calc_len(input logic [MS_W-1:0] ms, input logic [RATE_W-1:0] rate);
		logic [RATE_W:0]   rsum;
		logic [KHZ_W-1:0]  khz;
		logic [PLEN_W-1:0] plen;
		len_t              r;
		rsum = {1'b0, rate} + RATE_ROUND;
		khz  = rsum[RATE_W:KHZ_SHIFT];
		plen = PLEN_W'(ms) * PLEN_W'(khz);
		if (plen == '0) begin
			r = LEN_MIN;
		end else if (plen > PLEN_W'(MAX_DELAY)) begin
			r = LEN_MAX;
		end else begin
			r = plen[LEN_W-1:0];
		end
		return r;
	endfunction

endpackage

`default_nettype wire

>>> hdl/fedl_in_if.sv
// Valid/ready channel that carries dry input samples.
`default_nettype none

interface fedl_in_if import fedl_pkg::*; ();
	logic    valid;
	logic    ready;
	sample_t sample_in;

	modport source (output valid, output sample_in, input ready);
	modport sink (input valid, input sample_in, output ready);
endinterface

`default_nettype wire

>>> hdl/fedl_out_if.sv
// Valid/ready channel that carries echoed output samples.
`default_nettype none

interface fedl_out_if import fedl_pkg::*; ();
	logic    valid;
	logic    ready;
	sample_t sample_out;

	modport source (output valid, output sample_out, input ready);
	modport sink (input valid, input sample_out, output ready);
endinterface

`default_nettype wire

>>> hdl/fedl_ram.sv
// Generic single-write, single-read RAM with a registered read port.
`default_nettype none

module fedl_ram #(
	parameter int unsigned WIDTH = 16,
	parameter int unsigned DEPTH = 8192,
	parameter int unsigned AW    = $clog2(DEPTH)
) (
	input  wire logic             clk,
	input  wire logic             we,
	input  wire logic [AW-1:0]    waddr,
	input  wire logic [WIDTH-1:0] wdata,
	input  wire logic             re,
	input  wire logic [AW-1:0]    raddr,
	output logic      [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata_q <= mem_q[raddr];
		end
	end

	assign rdata = rdata_q;

endmodule

`default_nettype wire

>>> hdl/feedback_echo_delay_line.sv
// Feedback comb filter echo on signed 16-bit samples with a Q15 feedback gain.
//
// Dry samples arrive on in_chan and echoed samples leave on out_chan, both
// valid/ready channels; a request moves when valid and ready are both high.
// Each sample reads the delay line at the current position, adds the delayed
// sample scaled by feedback_gain, saturates, and writes the result back.
// The configuration port takes one register write per cycle while cfg_we is
// high: index 0 feedback_gain, 1 echo_delay_ms, 2 sample_rate_hz. Writing the
// delay or the rate recomputes the delay length.
// An accepted request passes the input stage and the output register to out_chan.
// One request is taken every cycle unless out_chan stalls or the line is cleared;
// the rate is set by the single delay line RAM, read at acceptance and written as
// the result leaves the input stage, with the last entry forwarded to the next reader.
// After reset all 8192 delay line entries are cleared to zero, one entry per
// cycle, and in_chan.ready stays low for that time.
// When out_chan stalls, the result is held; one more request is accepted into
// the input stage, and ready then drops until the output is taken.
`default_nettype none

module feedback_echo_delay_line import fedl_pkg::*; (
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	fedl_in_if.sink                    in_chan,
	fedl_out_if.source                 out_chan,
	input  wire logic                  cfg_we,
	input  wire logic [CFG_IDX_W-1:0]  cfg_index,
	input  wire logic [CFG_DATA_W-1:0] cfg_data
);

	gain_t              gain_q;
	logic [MS_W-1:0]    ms_q;
	logic [RATE_W-1:0]  rate_q;
	len_t               len_q;
	addr_t              pos_q;

	logic               clearing_q;
	addr_t              clr_addr_q;

	logic               valid_s1;
	sample_t            dry_s1;
	addr_t              addr_s1;

	logic               wr_vld_q;
	addr_t              wr_addr_q;
	sample_t            wr_data_q;

	logic               out_vld_q;
	sample_t            out_data_q;

	logic               accept;
	logic               advance;
	addr_t              pos_use;
	logic [ADDR_W:0]    pos_inc;
	addr_t              pos_next;

	logic [SAMPLE_W-1:0] ram_rdata;
	logic               ram_we;
	addr_t              ram_waddr;
	logic [SAMPLE_W-1:0] ram_wdata;

	sample_t                   entry;
	logic signed [2*SAMPLE_W-1:0] prod;
	sample_t                   wet;
	logic signed [SAMPLE_W:0]  sum;
	sample_t                   res;

	assign advance = !out_vld_q || out_chan.ready;
	assign in_chan.ready = !clearing_q && (!valid_s1 || advance);
	assign accept = in_chan.valid && in_chan.ready;

	assign pos_use  = ({1'b0, pos_q} >= len_q) ? '0 : pos_q;
	assign pos_inc  = {1'b0, pos_use} + (ADDR_W+1)'(1);
	assign pos_next = (pos_inc >= len_q) ? '0 : pos_inc[ADDR_W-1:0];

	assign entry = (wr_vld_q && wr_addr_q == addr_s1) ? wr_data_q : sample_t'(ram_rdata);
	assign prod  = entry * gain_q;
	assign wet   = sat16(prod[2*SAMPLE_W-1:SAMPLE_W-1]);
	assign sum   = {dry_s1[SAMPLE_W-1], dry_s1} + {wet[SAMPLE_W-1], wet};
	assign res   = sat16(sum);

	assign ram_we    = clearing_q || (valid_s1 && advance);
	assign ram_waddr = clearing_q ? clr_addr_q : addr_s1;
	assign ram_wdata = clearing_q ? '0 : res;

	fedl_ram #(
		.WIDTH (SAMPLE_W),
		.DEPTH (MAX_DELAY),
		.AW    (ADDR_W)
	) u_line (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (ram_wdata),
		.re    (accept),
		.raddr (pos_use),
		.rdata (ram_rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			gain_q <= '0;
			ms_q   <= '0;
			rate_q <= RATE_RESET;
			len_q  <= LEN_MAX;
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_FEEDBACK_GAIN: begin
					gain_q <= cfg_data[GAIN_W-1:0];
				end
				REG_ECHO_DELAY_MS: begin
					ms_q  <= cfg_data[MS_W-1:0];
					len_q <= calc_len(cfg_data[MS_W-1:0], rate_q);
				end
				REG_SAMPLE_RATE_HZ: begin
					rate_q <= cfg_data[RATE_W-1:0];
					len_q  <= calc_len(ms_q, cfg_data[RATE_W-1:0]);
				end
				default: begin
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clearing_q <= 1'b1;
			clr_addr_q <= '0;
		end else if (clearing_q) begin
			clr_addr_q <= clr_addr_q + ADDR_W'(1);
			if (clr_addr_q == addr_t'(MAX_DELAY - 1)) begin
				clearing_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q    <= '0;
			valid_s1 <= 1'b0;
		end else if (accept) begin
			pos_q    <= pos_next;
			valid_s1 <= 1'b1;
		end else if (advance) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			dry_s1  <= in_chan.sample_in;
			addr_s1 <= pos_use;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_vld_q  <= 1'b0;
			out_vld_q <= 1'b0;
		end else begin
			if (valid_s1 && advance) begin
				wr_vld_q <= 1'b1;
			end
			if (advance) begin
				out_vld_q <= valid_s1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (valid_s1 && advance) begin
			wr_addr_q  <= addr_s1;
			wr_data_q  <= res;
			out_data_q <= res;
		end
	end

	assign out_chan.valid      = out_vld_q;
	assign out_chan.sample_out = out_data_q;

	a_len_range: assert property (@(posedge clk) disable iff (!arst_n)
		len_q != '0 && len_q <= LEN_MAX)
		else $error("delay length out of range");

	a_pos_wrap: assert property (@(posedge clk) disable iff (!arst_n)
		(accept && !cfg_we) |=> ({1'b0, pos_q} < len_q))
		else $error("position not wrapped below the delay length");

	a_no_work_in_clear: assert property (@(posedge clk) disable iff (!arst_n)
		clearing_q |-> (!valid_s1 && !out_vld_q))
		else $error("sample in flight while the delay line is being cleared");

	a_out_from_stage: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_vld_q) |-> $past(valid_s1))
		else $error("result appeared without a sample in the input stage");

	a_write_matches_out: assert property (@(posedge clk) disable iff (!arst_n)
		(valid_s1 && advance) |=> (wr_vld_q && out_vld_q && wr_data_q == out_data_q))
		else $error("written-back sample differs from the delivered sample");

endmodule

`default_nettype wire
